>>> rtl/ascii_hex_frame_parser_top_defines.svh
// Assertion macros used by the parser top level.
// All checks run on i_clk and are disabled while i_rst_n is low.
`ifndef ASCII_HEX_FRAME_PARSER_TOP_DEFINES_SVH
`define ASCII_HEX_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication
`define AHFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define AHFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ahfp_pkg.sv
`default_nettype none
package ahfp_pkg;

    // Frame layout
    localparam int unsigned BASE_FRAME_LEN = 12;
    localparam int unsigned CHECK_LEN      = 2;
    localparam int unsigned FILL_W         = 4;
    // Entries that decode ever reads: start byte, ten digits, two checksum digits
    localparam int unsigned DECODE_SPAN    = 13;
    localparam int unsigned DATA_W         = 40;

    localparam logic [7:0] START_CHAR = 8'h3A;
    localparam logic [7:0] END_CHAR   = 8'h0A;

    typedef logic [7:0] t_byte;

    // One decoded hex digit
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // One result word, instruction in the low bits
    typedef struct packed {
        logic [15:0] second_value;
        logic [15:0] first_value;
        logic [7:0]  instruction;
    } t_result;

    function automatic t_hex hex_digit(input t_byte c);
        t_hex  h;
        t_byte d;
        h = '0;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            h.ok = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            h.ok = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            h.ok = 1'b1;
        end
        h.val = d[3:0];
        return h;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ahfp_frame_acc.sv
`default_nettype none
module ahfp_frame_acc
    import ahfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_byte   i_byte,
    input  wire logic    i_check_enable,
    output logic         o_emit,
    output t_result      o_result
);

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] w_len;
    logic [FILL_W-1:0] w_pos;
    logic              w_restart;
    t_byte             r_store [0:DECODE_SPAN-1];
    t_hex              w_hex   [1:DECODE_SPAN-1];
    t_byte             w_xor;
    logic              w_fields_ok;
    logic              w_cs_ok;

    // Fill position: restart on ':' or once the frame length is reached
    always_comb begin
        w_len     = i_check_enable ? FILL_W'(BASE_FRAME_LEN + CHECK_LEN)
                                   : FILL_W'(BASE_FRAME_LEN);
        w_restart = (i_byte == START_CHAR) || (r_fill >= w_len);
        w_pos     = w_restart ? '0 : r_fill;
        n_fill    = w_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_step) begin
            r_fill <= n_fill;
        end
    end

    // Frame store; the final newline slot is never read back
    always_ff @(posedge i_clk) begin
        if (i_step && (w_pos < FILL_W'(DECODE_SPAN))) begin
            r_store[w_pos] <= i_byte;
        end
    end

    // Digit decode of all stored hex positions
    always_comb begin
        for (int i = 1; i < DECODE_SPAN; i++) begin
            w_hex[i] = hex_digit(r_store[i]);
        end
    end

    // Checksum over the first eleven bytes, as a balanced tree
    assign w_xor = ((r_store[0] ^ r_store[1]) ^ (r_store[2] ^ r_store[3]))
                 ^ ((r_store[4] ^ r_store[5]) ^ (r_store[6] ^ r_store[7]))
                 ^ ((r_store[8] ^ r_store[9]) ^ r_store[10]);

    always_comb begin
        w_fillsafe_dummy_free: begin
            w_fields_ok = w_hex[1].ok & w_hex[2].ok & w_hex[3].ok & w_hex[4].ok
                        & w_hex[5].ok & w_hex[6].ok & w_hex[7].ok & w_hex[8].ok
                        & w_hex[9].ok & w_hex[10].ok;
            w_cs_ok     = !i_check_enable
                        || (w_hex[11].ok && w_hex[12].ok
                            && ({w_hex[11].val, w_hex[12].val} == w_xor));
        end
    end

    // Decode fires on a newline that lands exactly at the frame length
    assign o_emit = i_step && (i_byte == END_CHAR) && (n_fill == w_len)
                 && w_fields_ok && w_cs_ok;

    assign o_result.instruction  = {w_hex[1].val, w_hex[2].val};
    assign o_result.first_value  = {w_hex[3].val, w_hex[4].val,
                                    w_hex[5].val, w_hex[6].val};
    assign o_result.second_value = {w_hex[7].val, w_hex[8].val,
                                    w_hex[9].val, w_hex[10].val};

endmodule
`default_nettype wire

>>> rtl/ahfp_out_reg.sv
`default_nettype none
module ahfp_out_reg
    import ahfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire t_result           i_result,
    input  wire logic              i_tready,
    output logic                   o_tvalid,
    output logic [DATA_W-1:0]      o_tdata
);

    logic    r_valid;
    t_result r_result;

    // Result word holds until taken; load only happens when there is room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = DATA_W'(r_result);

endmodule
`default_nettype wire

>>> rtl/ascii_hex_frame_parser_top.sv
// ASCII hex frame parser. Takes one received character per word on the
// slave side, one word every clock unless a result waits on m_axis_tready,
// and emits {instruction, first_value, second_value} on the master side
// for each frame ':' II AAAA BBBB [CC] '\n' that decodes with valid hex
// digits and, when i_cfg_wdata last wrote 1 (the reset value), a matching
// XOR checksum over the first eleven bytes. A word passes an input register,
// then frame update and decode into the result register; with the result
// slot free, m_axis_tvalid rises once the newline has passed both. A result
// waiting on m_axis_tready holds every byte: one more byte is taken into the
// input register, then s_axis_tready drops until the result is taken.
// Write i_cfg_we only while the parser is idle.
`default_nettype none
`include "ascii_hex_frame_parser_top_defines.svh"
module ascii_hex_frame_parser_top
    import ahfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,     // check_enable
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,    // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata     // [7:0] instruction,
                                                    // [23:8] first_value,
                                                    // [39:24] second_value
);

    logic    r_check_enable;
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    w_go;
    logic    w_emit;
    t_result w_result;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_check_enable <= i_cfg_wdata;
        end
    end

    // Input register; processed when the result slot is free or draining
    assign w_go          = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    ahfp_frame_acc u_frame_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_go),
        .i_byte         (r_in_byte),
        .i_check_enable (r_check_enable),
        .o_emit         (w_emit),
        .o_result       (w_result)
    );

    ahfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit),
        .i_result (w_result),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata)
    );

    // A decoded frame must show up on the master side next cycle
    `AHFP_ASSERT_NEXT(a_emit_shows, w_emit, m_axis_tvalid, "decoded frame not presented")
    // A pending byte is never dropped or overwritten
    `AHFP_ASSERT_NEXT(a_in_hold, r_in_valid && !w_go,
        r_in_valid && $stable(r_in_byte), "pending input byte lost")
    // With the result slot empty the slave side must be open
    `AHFP_ASSERT_SAME(a_ready_open, !m_axis_tvalid, s_axis_tready, "input stalled with no result")
    // Decode only fires while a word is being processed
    `AHFP_ASSERT_SAME(a_emit_step, w_emit, w_go && (r_in_byte == END_CHAR),
        "decode without a newline step")

endmodule
`default_nettype wire
